// ===== rtl/csl_pkg.sv =====
// shared types, keyword table and character class helpers for the lexer
package csl_pkg;

	localparam int NUM_KW = 9;

	localparam logic [2:0] CLASS_KEYWORD    = 3'd0;
	localparam logic [2:0] CLASS_NUMBER     = 3'd1;
	localparam logic [2:0] CLASS_IDENTIFIER = 3'd2;
	localparam logic [2:0] CLASS_OPERATOR   = 3'd3;
	localparam logic [2:0] CLASS_SYMBOL     = 3'd4;

	localparam logic KIND_CHAR  = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// int float double char return if else for while, padded with zeros
	localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
		'{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h66, 8'h6C, 8'h6F, 8'h61, 8'h74, 8'h00, 8'h00, 8'h00},
		'{8'h64, 8'h6F, 8'h75, 8'h62, 8'h6C, 8'h65, 8'h00, 8'h00},
		'{8'h63, 8'h68, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E, 8'h00, 8'h00},
		'{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h66, 8'h6F, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00, 8'h00, 8'h00}
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{
		3'd3, 3'd5, 3'd6, 3'd4, 3'd6, 3'd2, 3'd4, 3'd3, 3'd5
	};

	typedef struct packed {
		logic [2:0]  token_class;
		logic [31:0] token_start;
		logic [15:0] token_length;
		logic [3:0]  keyword_index;
		logic [7:0]  single_char;
		logic        last_of_run;
	} token_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_operator(input logic [7:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) ||
			(c == CH_EQ) || (c == CH_LT) || (c == CH_GT);
	endfunction

	function automatic logic is_symbol(input logic [7:0] c);
		return (c == CH_SEMI) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
			(c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_COMMA);
	endfunction

	function automatic logic is_numeric(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || (c == CH_DOT);
	endfunction

endpackage

// ===== rtl/csl_char_if.sv =====
// character input channel: valid, ready and one stream item
interface csl_char_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] char_byte;

	modport source (output valid, kind, char_byte, input ready);
	modport sink (input valid, kind, char_byte, output ready);
endinterface

// ===== rtl/csl_token_if.sv =====
// token output channel: valid, ready and one result item
interface csl_token_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_class;
	logic [31:0] token_start;
	logic [15:0] token_length;
	logic [3:0]  keyword_index;
	logic [7:0]  single_char;
	logic        last_of_run;

	modport source (output valid, token_class, token_start, token_length, keyword_index,
		single_char, last_of_run, input ready);
	modport sink (input valid, token_class, token_start, token_length, keyword_index,
		single_char, last_of_run, output ready);
endinterface

// ===== rtl/c_subset_lexer.sv =====
// byte-serial lexer for a small c subset: keywords, numbers, identifiers, operators, symbols
// results are registered in the result queue and shown on token_out once older ones are taken
// throughput: one character per cycle; a four-entry result queue holds up to two results per item
// input stalls only while fewer than two queue entries are free
// reset: arst_n clears the pending word, position counter and queue; no warm-up after release
module c_subset_lexer
	import csl_pkg::*;
#(
	parameter int LENGTH_BITS   = 16,
	parameter int POSITION_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	csl_char_if.sink char_in,
	csl_token_if.source token_out
);

	logic [LENGTH_BITS-1:0]   word_len_q;
	logic [NUM_KW-1:0]        alive_q;
	logic                     numeric_q;
	logic [POSITION_BITS-1:0] word_start_q;
	logic [POSITION_BITS-1:0] pos_q;

	token_t     fifo_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;

	logic       accept;
	logic       pop;
	logic [7:0] c;
	logic       has_word;
	logic       kw_hit;
	logic [3:0] kw_idx;
	logic [NUM_KW-1:0] alive_nxt;
	logic       ends_word;
	logic       single;
	logic       extend;
	logic [1:0] push_n;
	token_t     word_tok;
	token_t     single_tok;
	token_t     r0;
	token_t     r1;
	logic [LENGTH_BITS+15:0]   len_ext;
	logic [POSITION_BITS+31:0] wstart_ext;
	logic [POSITION_BITS+31:0] pos_ext;

	assign c      = char_in.char_byte;
	assign accept = char_in.valid && char_in.ready;
	assign pop    = token_out.valid && token_out.ready;
	assign has_word = word_len_q != '0;

	assign char_in.ready = count_q <= 3'd2;

	assign len_ext    = {16'b0, word_len_q};
	assign wstart_ext = {32'b0, word_start_q};
	assign pos_ext    = {32'b0, pos_q};

	always_comb begin
		kw_hit = 1'b0;
		kw_idx = 4'd0;
		for (int i = 0; i < NUM_KW; i++) begin
			if (alive_q[i] && word_len_q == LENGTH_BITS'(KW_LEN[i])) begin
				kw_hit = 1'b1;
				kw_idx = 4'(i);
			end
			alive_nxt[i] = alive_q[i] && (word_len_q < LENGTH_BITS'(KW_LEN[i])) &&
				(KW_TEXT[i][word_len_q[2:0]] == c);
		end
	end

	always_comb begin
		word_tok.token_class   = kw_hit ? CLASS_KEYWORD :
			(numeric_q ? CLASS_NUMBER : CLASS_IDENTIFIER);
		word_tok.token_start   = wstart_ext[31:0];
		word_tok.token_length  = len_ext[15:0];
		word_tok.keyword_index = kw_idx;
		word_tok.single_char   = 8'd0;
		word_tok.last_of_run   = 1'b1;

		single_tok.token_class   = is_operator(c) ? CLASS_OPERATOR : CLASS_SYMBOL;
		single_tok.token_start   = pos_ext[31:0];
		single_tok.token_length  = 16'd1;
		single_tok.keyword_index = 4'd0;
		single_tok.single_char   = c;
		single_tok.last_of_run   = 1'b1;
	end

	always_comb begin
		single    = (char_in.kind == KIND_CHAR) && (is_operator(c) || is_symbol(c));
		ends_word = (char_in.kind == KIND_FLUSH) || is_space(c) || single;
		extend    = !ends_word;
		r0        = word_tok;
		r1        = single_tok;
		push_n    = 2'd0;
		if (single) begin
			if (has_word) begin
				r0.last_of_run = 1'b0;
				push_n = 2'd2;
			end else begin
				r0 = single_tok;
				push_n = 2'd1;
			end
		end else if (ends_word && has_word) begin
			push_n = 2'd1;
		end
	end

	// word tracking and stream position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_len_q   <= '0;
			alive_q      <= '1;
			numeric_q    <= 1'b1;
			word_start_q <= '0;
			pos_q        <= '0;
		end else if (accept) begin
			if (char_in.kind == KIND_CHAR) begin
				pos_q <= pos_q + 1'b1;
			end
			if (extend) begin
				if (!has_word) begin
					word_start_q <= pos_q;
				end
				alive_q   <= alive_nxt;
				numeric_q <= numeric_q && is_numeric(c);
				if (word_len_q != '1) begin
					word_len_q <= word_len_q + 1'b1;
				end
			end else begin
				word_len_q <= '0;
				alive_q    <= '1;
				numeric_q  <= 1'b1;
			end
		end
	end

	// result queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + (accept ? push_n : 2'd0);
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_q + {1'b0, (accept ? push_n : 2'd0)} - {2'b0, pop};
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (accept && push_n != 2'd0) begin
			fifo_q[wr_ptr_q] <= r0;
		end
		if (accept && push_n == 2'd2) begin
			fifo_q[wr_ptr_q + 2'd1] <= r1;
		end
	end

	assign token_out.valid         = count_q != 3'd0;
	assign token_out.token_class   = fifo_q[rd_ptr_q].token_class;
	assign token_out.token_start   = fifo_q[rd_ptr_q].token_start;
	assign token_out.token_length  = fifo_q[rd_ptr_q].token_length;
	assign token_out.keyword_index = fifo_q[rd_ptr_q].keyword_index;
	assign token_out.single_char   = fifo_q[rd_ptr_q].single_char;
	assign token_out.last_of_run   = fifo_q[rd_ptr_q].last_of_run;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result queue overfilled");

	a_long_word_no_kw: assert property (@(posedge clk) disable iff (!arst_n)
		(word_len_q > LENGTH_BITS'(6)) |-> (alive_q == '0))
		else $error("keyword still alive past longest keyword");

	a_empty_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && char_in.kind == KIND_FLUSH && !has_word) |=> (count_q <= $past(count_q)))
		else $error("flush with no pending word produced a result");

	a_single_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && single) |=> (count_q != 3'd0))
		else $error("operator or symbol produced no result");

endmodule

// ===== tb/sv/tb_c_subset_lexer.sv =====
// self-checking bench for c_subset_lexer: directed rows, random c-like streams, one long digit run
module tb_c_subset_lexer;
	import csl_pkg::*;

	localparam int CYCLE_LIMIT = 60000;
	localparam int PHASE_ITEMS = 330;
	localparam int LONG_WORD   = 40;
	localparam logic [3:0] KWI_INT = 4'd0;

	localparam logic [7:0] OP_CHARS [7] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQ, CH_LT, CH_GT};
	localparam logic [7:0] SYM_CHARS [6] = '{CH_SEMI, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
		CH_COMMA};
	localparam logic [7:0] BLANK_CHARS [6] = '{CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR, CH_SPACE};

	typedef struct {
		logic       kind;
		logic [7:0] ch;
		bit         typed;
		token_t     want;
	} stim_row_t;

	localparam int N_ROWS = 27;
	stim_row_t directed_rows [N_ROWS] = '{
		'{KIND_CHAR, CH_SEMI, 1'b1, '{CLASS_SYMBOL, 32'd0, 16'd1, KWI_INT, CH_SEMI, 1'b1}},
		'{KIND_CHAR, "i", 1'b0, '0},
		'{KIND_CHAR, "n", 1'b0, '0},
		'{KIND_CHAR, "t", 1'b0, '0},
		'{KIND_CHAR, CH_SPACE, 1'b1, '{CLASS_KEYWORD, 32'd1, 16'd3, KWI_INT, 8'd0, 1'b1}},
		'{KIND_CHAR, "w", 1'b0, '0},
		'{KIND_CHAR, "h", 1'b0, '0},
		'{KIND_CHAR, "i", 1'b0, '0},
		'{KIND_CHAR, "l", 1'b0, '0},
		'{KIND_CHAR, "e", 1'b0, '0},
		'{KIND_CHAR, CH_LPAREN, 1'b0, '0},
		'{KIND_CHAR, CH_DOT, 1'b0, '0},
		'{KIND_FLUSH, 8'h00, 1'b0, '0},
		'{KIND_FLUSH, 8'hFF, 1'b0, '0},
		'{KIND_CHAR, 8'hFF, 1'b0, '0},
		'{KIND_CHAR, 8'h00, 1'b0, '0},
		'{KIND_CHAR, CH_PLUS, 1'b0, '0},
		'{KIND_CHAR, CH_NINE, 1'b0, '0},
		'{KIND_CHAR, CH_CR, 1'b0, '0},
		'{KIND_CHAR, CH_MINUS, 1'b0, '0},
		'{KIND_CHAR, "i", 1'b0, '0},
		'{KIND_CHAR, "f", 1'b0, '0},
		'{KIND_CHAR, CH_RBRACE, 1'b0, '0},
		'{KIND_CHAR, 8'h08, 1'b0, '0},
		'{KIND_CHAR, CH_LBRACE, 1'b0, '0},
		'{KIND_CHAR, "7", 1'b0, '0},
		'{KIND_FLUSH, 8'h00, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	csl_char_if  char_ch ();
	csl_token_if tok_ch ();

	c_subset_lexer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_in   (char_ch),
		.token_out (tok_ch)
	);

	// lexer state as the bench sees it
	logic [15:0] word_len     = '0;
	logic [8:0]  kw_alive     = '1;
	logic        numeric_only = 1'b1;
	logic [31:0] word_start   = '0;
	logic [31:0] stream_pos   = '0;

	token_t step_tok [2];
	int     step_n;
	token_t pending_tokens [$];

	bit     row_typed = 1'b0;
	token_t row_tok   = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int sent_items    = 0;
	int taken_items   = 0;
	int err_count     = 0;
	int cycles        = 0;
	int class_seen [5] = '{0, 0, 0, 0, 0};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_tokens.size());
			$display("tb: failure");
			$finish;
		end
	end

	function automatic bit is_blank_char(input logic [7:0] c);
		foreach (BLANK_CHARS[i])
			if (c == BLANK_CHARS[i]) return 1'b1;
		return 1'b0;
	endfunction

	function automatic bit in_list_op(input logic [7:0] c);
		foreach (OP_CHARS[i])
			if (c == OP_CHARS[i]) return 1'b1;
		return 1'b0;
	endfunction

	function automatic bit in_list_sym(input logic [7:0] c);
		foreach (SYM_CHARS[i])
			if (c == SYM_CHARS[i]) return 1'b1;
		return 1'b0;
	endfunction

	task automatic close_word();
		token_t t;
		bit     hit;
		hit = 1'b0;
		t = '0;
		if (word_len != 0) begin
			for (int i = 0; i < NUM_KW; i++)
				if (kw_alive[i] && word_len == 16'(KW_LEN[i])) begin
					hit = 1'b1;
					t.keyword_index = 4'(i);
				end
			t.token_class  = hit ? CLASS_KEYWORD : (numeric_only ? CLASS_NUMBER : CLASS_IDENTIFIER);
			t.token_start  = word_start;
			t.token_length = word_len;
			step_tok[step_n] = t;
			step_n++;
			word_len     = '0;
			kw_alive     = '1;
			numeric_only = 1'b1;
		end
	endtask

	task automatic extend_word(input logic [7:0] c, input logic [31:0] pos);
		logic [8:0] still;
		still = '0;
		if (word_len == 0) word_start = pos;
		// a keyword stays alive only while the word is a prefix of it
		for (int i = 0; i < NUM_KW; i++)
			if (kw_alive[i] && word_len < 16'(KW_LEN[i]) && KW_TEXT[i][word_len[2:0]] == c)
				still[i] = 1'b1;
		kw_alive = still;
		if (!((c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT)) numeric_only = 1'b0;
		if (word_len != 16'hFFFF) word_len++;
	endtask

	task automatic lex_predict(input logic k, input logic [7:0] c);
		logic [31:0] pos_now;
		token_t      t;
		step_n = 0;
		pos_now = stream_pos;
		if (k == KIND_FLUSH) begin
			close_word();
		end else begin
			stream_pos++;
			if (is_blank_char(c)) begin
				close_word();
			end else if (in_list_op(c) || in_list_sym(c)) begin
				close_word();
				t = '0;
				t.token_class  = in_list_op(c) ? CLASS_OPERATOR : CLASS_SYMBOL;
				t.token_start  = pos_now;
				t.token_length = 16'd1;
				t.single_char  = c;
				step_tok[step_n] = t;
				step_n++;
			end else begin
				extend_word(c, pos_now);
			end
		end
		if (step_n > 0) step_tok[step_n - 1].last_of_run = 1'b1;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		err_count++;
		$display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycles, what, got, want);
	endtask

	// transfer accounting: prediction on the input side, comparison on the output side
	always @(posedge clk) begin
		token_t got;
		token_t want;
		if (arst_n && char_ch.valid === 1'b1 && char_ch.ready === 1'b1) begin
			lex_predict(char_ch.kind, char_ch.char_byte);
			taken_items++;
			if (row_typed)
				pending_tokens.push_back(row_tok);
			else
				for (int i = 0; i < step_n; i++) pending_tokens.push_back(step_tok[i]);
		end
		if (arst_n && tok_ch.valid === 1'b1 && tok_ch.ready === 1'b1) begin
			got = '{tok_ch.token_class, tok_ch.token_start, tok_ch.token_length,
				tok_ch.keyword_index, tok_ch.single_char, tok_ch.last_of_run};
			if (pending_tokens.size() == 0) begin
				report_mismatch("unexpected token", 32'(got.token_class), '0);
			end else begin
				want = pending_tokens.pop_front();
				if (want.token_class < 5) class_seen[want.token_class]++;
				if (got.token_class !== want.token_class)
					report_mismatch("token_class", 32'(got.token_class), 32'(want.token_class));
				if (got.token_start !== want.token_start)
					report_mismatch("token_start", got.token_start, want.token_start);
				if (got.token_length !== want.token_length)
					report_mismatch("token_length", 32'(got.token_length), 32'(want.token_length));
				if (got.keyword_index !== want.keyword_index)
					report_mismatch("keyword_index", 32'(got.keyword_index),
						32'(want.keyword_index));
				if (got.single_char !== want.single_char)
					report_mismatch("single_char", 32'(got.single_char), 32'(want.single_char));
				if (got.last_of_run !== want.last_of_run)
					report_mismatch("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
			end
		end
	end

	initial begin
		tok_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			tok_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_char(input logic k, input logic [7:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			char_ch.valid <= 1'b0;
			@(negedge clk);
		end
		char_ch.valid     <= 1'b1;
		char_ch.kind      <= k;
		char_ch.char_byte <= c;
		@(posedge clk);
		while (char_ch.ready !== 1'b1) @(posedge clk);
		sent_items++;
		@(negedge clk);
		row_typed = 1'b0;
	endtask

	task automatic send_separator();
		int sel;
		sel = $urandom_range(9);
		if (sel < 5)
			send_char(KIND_CHAR, BLANK_CHARS[$urandom_range(5)]);
		else if (sel < 8)
			send_char(KIND_CHAR, OP_CHARS[$urandom_range(6)]);
		else
			send_char(KIND_CHAR, SYM_CHARS[$urandom_range(5)]);
	endtask

	// one lexical piece of a c-like stream, with some noise and broken keywords
	task automatic send_piece();
		int sel;
		int kw;
		int len;
		int cut;
		logic [7:0] c;
		sel = $urandom_range(99);
		if (sel < 25) begin
			kw = $urandom_range(NUM_KW - 1);
			len = KW_LEN[kw];
			cut = $urandom_range(99);
			if (cut < 12) len--;
			for (int j = 0; j < len; j++) send_char(KIND_CHAR, KW_TEXT[kw][j]);
			if (cut >= 88) send_char(KIND_CHAR, "x");
			if ($urandom_range(99) < 75) send_separator();
		end else if (sel < 40) begin
			len = $urandom_range(1, 8);
			for (int j = 0; j < len; j++) begin
				case ($urandom_range(3))
					0: c = 8'($urandom_range(8'h61, 8'h7A));
					1: c = 8'($urandom_range(8'h41, 8'h5A));
					2: c = (j == 0) ? 8'h5F : 8'($urandom_range(CH_ZERO, CH_NINE));
					default: c = 8'($urandom_range(8'h61, 8'h66));
				endcase
				send_char(KIND_CHAR, c);
			end
			if ($urandom_range(99) < 75) send_separator();
		end else if (sel < 52) begin
			len = $urandom_range(1, 6);
			for (int j = 0; j < len; j++)
				send_char(KIND_CHAR, ($urandom_range(7) == 0) ? CH_DOT :
					8'($urandom_range(CH_ZERO, CH_NINE)));
			if ($urandom_range(99) < 75) send_separator();
		end else if (sel < 82) begin
			send_separator();
		end else if (sel < 96) begin
			send_char(KIND_CHAR, 8'($urandom_range(255)));
		end else begin
			send_char(KIND_FLUSH, 8'($urandom_range(255)));
		end
	endtask

	initial begin
		char_ch.valid     = 1'b0;
		char_ch.kind      = KIND_CHAR;
		char_ch.char_byte = 8'h00;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 26;
		recv_idle_pct = 45;
		foreach (directed_rows[r]) begin
			row_typed = directed_rows[r].typed;
			row_tok   = directed_rows[r].want;
			send_char(directed_rows[r].kind, directed_rows[r].ch);
		end
		while (sent_items < N_ROWS + PHASE_ITEMS) send_piece();

		send_idle_pct = 45;
		recv_idle_pct = 26;
		while (sent_items < N_ROWS + 2 * PHASE_ITEMS) send_piece();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (sent_items < N_ROWS + 3 * PHASE_ITEMS) send_piece();

		// one digit run far past the longest keyword
		for (int j = 0; j < LONG_WORD; j++) send_char(KIND_CHAR, "5");
		send_char(KIND_CHAR, CH_SEMI);
		char_ch.valid <= 1'b0;

		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (pending_tokens.size() != 0)
			report_mismatch("tokens never delivered", 32'(pending_tokens.size()), '0);

		$display("summary: %0d stream items in (one %0d-byte number), %0d mismatches",
			taken_items, LONG_WORD, err_count);
		$display("summary: keywords %0d, numbers %0d, identifiers %0d, operators %0d, symbols %0d",
			class_seen[0], class_seen[1], class_seen[2], class_seen[3], class_seen[4]);
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/csl_pkg.sv
rtl/csl_char_if.sv
rtl/csl_token_if.sv
rtl/c_subset_lexer.sv
tb/sv/tb_c_subset_lexer.sv
